FILE: rtl/scene_luminance_key_statistics_assert.svh
// assertion helpers used by the rtl top level
`ifndef SCENE_LUMINANCE_KEY_STATISTICS_ASSERT_SVH
`define SCENE_LUMINANCE_KEY_STATISTICS_ASSERT_SVH

// same-cycle implication
`define SLKS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slks same-cycle check failed");

// next-cycle implication
`define SLKS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slks next-cycle check failed");

`endif

FILE: rtl/slks_pkg.sv
// ----------------------------------------------------------------------------
// slks_pkg
// Shared constants, types and sequencer states of the luminance key statistics.
// ----------------------------------------------------------------------------
`default_nettype none

package slks_pkg;

  localparam int PIXEL_COUNT_BITS = 22;
  localparam int LOG_FRAC_BITS    = 16;
  localparam int QUEUE_DEPTH      = 4;

  localparam logic [15:0] KEY_BASE_RESET = 16'd11796;
  localparam logic [15:0] LUM_MAX        = 16'd65280;
  localparam logic [15:0] LUM_WEIGHT_R   = 16'd69;
  localparam logic [15:0] LUM_WEIGHT_G   = 16'd172;
  localparam logic [15:0] LUM_WEIGHT_B   = 16'd15;

  typedef struct packed {
    logic [15:0] lum;
    logic        last;
  } pix_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PIX,
    ST_AVG_SET,
    ST_AVG_MUL,
    ST_AVG_CMP,
    ST_MIN,
    ST_MAX,
    ST_KEY,
    ST_DIV,
    ST_RHS_MUL,
    ST_RHS_ADD,
    ST_ALP_MUL,
    ST_ALP_CMP,
    ST_OUT
  } seq_state_t;

endpackage

`default_nettype wire

FILE: rtl/slks_pixel_if.sv
// ----------------------------------------------------------------------------
// slks_pixel_if
// Pixel request channel: one rgb pixel and its end-of-frame mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface slks_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_channel;
  logic [7:0] green_channel;
  logic [7:0] blue_channel;
  logic       last_pixel;

  modport source (output valid, red_channel, green_channel, blue_channel, last_pixel,
                  input ready);
  modport sink   (input valid, red_channel, green_channel, blue_channel, last_pixel,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/slks_stats_if.sv
// ----------------------------------------------------------------------------
// slks_stats_if
// Frame statistics request channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface slks_stats_if;
  logic        valid;
  logic        ready;
  logic [15:0] min_luminance;
  logic [15:0] max_luminance;
  logic [15:0] log_average_luminance;
  logic [15:0] key_alpha;
  logic [22:0] frame_pixels;
  logic        flat_frame;

  modport source (output valid, min_luminance, max_luminance, log_average_luminance,
                  key_alpha, frame_pixels, flat_frame, input ready);
  modport sink   (input valid, min_luminance, max_luminance, log_average_luminance,
                  key_alpha, frame_pixels, flat_frame, output ready);
endinterface

`default_nettype wire

FILE: rtl/slks_front.sv
// ----------------------------------------------------------------------------
// slks_front
// Accepts pixels, forms the clamped Q8.8 luminance and queues it.
// ----------------------------------------------------------------------------
`default_nettype none

module slks_front #(
  parameter int QUEUE_DEPTH = slks_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  slks_pixel_if.sink         pixel,
  output slks_pkg::pix_t     q_item,
  output logic               q_valid,
  input  wire logic          q_pop
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  slks_pkg::pix_t   mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic [15:0]      lum_raw;
  slks_pkg::pix_t   item_in;

  assign pixel.ready = (count != CNT_W'(QUEUE_DEPTH));
  assign push        = pixel.valid && pixel.ready;
  assign q_valid     = (count != '0);
  assign q_item      = mem[rd_ptr];

  assign lum_raw = 16'(pixel.red_channel)   * slks_pkg::LUM_WEIGHT_R
                 + 16'(pixel.green_channel) * slks_pkg::LUM_WEIGHT_G
                 + 16'(pixel.blue_channel)  * slks_pkg::LUM_WEIGHT_B;

  always_comb begin
    item_in.lum  = (lum_raw == 16'd0) ? 16'd1 : lum_raw;
    item_in.last = pixel.last_pixel;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !q_pop) begin
        count <= count + CNT_W'(1);
      end else if (!push && q_pop) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/slks_log2.sv
// ----------------------------------------------------------------------------
// slks_log2
// Iterative fixed-point log2: leading-one index plus one squaring per
// fraction bit.
// ----------------------------------------------------------------------------
`default_nettype none

module slks_log2 #(
  parameter int LOG_FRAC_BITS = slks_pkg::LOG_FRAC_BITS
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [15:0]                value,
  output logic                            done,
  output logic [LOG_FRAC_BITS+3:0]        result
);

  localparam int STEP_W = $clog2(LOG_FRAC_BITS + 1);

  logic                     busy;
  logic [STEP_W-1:0]        step;
  logic [31:0]              x;
  logic [3:0]               k;
  logic [LOG_FRAC_BITS-1:0] frac;
  logic [15:0]              v;
  logic [3:0]               msb;
  logic [63:0]              sq;
  logic [31:0]              x2;

  always_comb begin
    v   = (value == 16'd0) ? 16'd1 : value;
    msb = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) begin
        msb = 4'(i);
      end
    end
  end

  assign sq     = 64'(x) * 64'(x);
  assign x2     = sq[61:30];
  assign result = {k, frac};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(LOG_FRAC_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      k    <= msb;
      x    <= 32'(v) << (5'd30 - 5'(msb));
      frac <= '0;
    end else if (busy) begin
      if (x2[31]) begin
        x    <= x2 >> 1;
        frac <= {frac[LOG_FRAC_BITS-2:0], 1'b1};
      end else begin
        x    <= x2;
        frac <= {frac[LOG_FRAC_BITS-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/slks_div.sv
// ----------------------------------------------------------------------------
// slks_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module slks_div #(
  parameter int NUM_W = 42,
  parameter int DEN_W = 23
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] dividend,
  input  wire logic [DEN_W-1:0] divisor,
  output logic                  done,
  output logic [NUM_W-1:0]      quotient
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [DEN_W:0]    rem;
  logic [DEN_W:0]    trial;
  logic [DEN_W-1:0]  den;

  assign trial = {rem[DEN_W-1:0], quotient[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      den      <= divisor;
      rem      <= '0;
    end else if (busy) begin
      if (trial >= {1'b0, den}) begin
        rem      <= trial - {1'b0, den};
        quotient <= {quotient[NUM_W-2:0], 1'b1};
      end else begin
        rem      <= trial;
        quotient <= {quotient[NUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/slks_back.sv
// ----------------------------------------------------------------------------
// slks_back
// Statistics sequencer: folds queued pixels into the frame statistics and,
// at frame end, searches the log average and, if not flat, the automatic key.
// ----------------------------------------------------------------------------
`default_nettype none

module slks_back #(
  parameter int PIXEL_COUNT_BITS = slks_pkg::PIXEL_COUNT_BITS,
  parameter int LOG_FRAC_BITS    = slks_pkg::LOG_FRAC_BITS
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [15:0]   key_base,
  input  wire slks_pkg::pix_t q_item,
  input  wire logic          q_valid,
  output logic               q_pop,
  slks_stats_if.source       stats
);

  localparam int LGW    = LOG_FRAC_BITS + 4;
  localparam int CNT_W  = PIXEL_COUNT_BITS + 1;
  localparam int LSUM_W = PIXEL_COUNT_BITS + 4 + LOG_FRAC_BITS;
  localparam int PA_W   = LGW + CNT_W;
  localparam int PD_W   = 2 * LGW;
  localparam int RHS_W  = PD_W + 2;
  localparam int NUM_W  = LGW + 3;

  slks_pkg::seq_state_t state, state_next;

  logic [15:0]        lum_cur, lum_cur_next;
  logic               last_cur, last_cur_next;
  logic [15:0]        running_min, running_min_next;
  logic [15:0]        running_max, running_max_next;
  logic [LSUM_W-1:0]  log_sum, log_sum_next;
  logic [CNT_W-1:0]   pixel_count, pixel_count_next;
  logic [15:0]        avg, avg_next;
  logic [15:0]        alpha, alpha_next;
  logic [3:0]         bitpos, bitpos_next;
  logic [LGW-1:0]     lmin, lmin_next;
  logic [LGW-1:0]     lmax, lmax_next;
  logic [LGW-1:0]     lgk, lgk_next;
  logic [LGW-1:0]     mean_c, mean_c_next;
  logic [PA_W-1:0]    prod_a, prod_a_next;
  logic [PD_W-1:0]    prod_d, prod_d_next;
  logic signed [RHS_W-1:0] rhs, rhs_next;
  logic               out_valid, out_valid_next;
  logic               out_load;

  logic [15:0]        bit_sel;
  logic [15:0]        cand;
  logic [CNT_W-1:0]   cnt_eff;
  logic [LGW-1:0]     den;
  logic               flat;
  logic signed [NUM_W-1:0] num;
  logic signed [RHS_W-1:0] rhs_sum;

  logic               lg_start;
  logic [15:0]        lg_value;
  logic               lg_done;
  logic [LGW-1:0]     lg_result;
  logic               div_start;
  logic               div_done;
  logic [LSUM_W-1:0]  quotient;

  slks_log2 #(
    .LOG_FRAC_BITS(LOG_FRAC_BITS)
  ) u_log2 (
    .clk   (clk),
    .rst   (rst),
    .start (lg_start),
    .value (lg_value),
    .done  (lg_done),
    .result(lg_result)
  );

  slks_div #(
    .NUM_W(LSUM_W),
    .DEN_W(CNT_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(log_sum),
    .divisor (cnt_eff),
    .done    (div_done),
    .quotient(quotient)
  );

  assign bit_sel = 16'd1 << bitpos;
  assign cand    = avg | bit_sel;
  assign cnt_eff = (pixel_count == '0) ? CNT_W'(1) : pixel_count;
  assign den     = lmax - lmin;
  assign flat    = (running_max == running_min);
  assign num     = $signed({2'b00, mean_c, 1'b0}) - $signed({3'b000, lmin})
                 - $signed({3'b000, lmax});
  assign rhs_sum = $signed({2'b00, prod_d}) + (RHS_W'(num) <<< (LOG_FRAC_BITS + 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= slks_pkg::ST_IDLE;
      out_valid   <= 1'b0;
      running_min <= 16'hFFFF;
      running_max <= 16'd0;
      log_sum     <= '0;
      pixel_count <= '0;
    end else begin
      state       <= state_next;
      out_valid   <= out_valid_next;
      running_min <= running_min_next;
      running_max <= running_max_next;
      log_sum     <= log_sum_next;
      pixel_count <= pixel_count_next;
    end
  end

  always_ff @(posedge clk) begin
    lum_cur  <= lum_cur_next;
    last_cur <= last_cur_next;
    avg      <= avg_next;
    alpha    <= alpha_next;
    bitpos   <= bitpos_next;
    lmin     <= lmin_next;
    lmax     <= lmax_next;
    lgk      <= lgk_next;
    mean_c   <= mean_c_next;
    prod_a   <= prod_a_next;
    prod_d   <= prod_d_next;
    rhs      <= rhs_next;
    if (out_load) begin
      stats.min_luminance         <= running_min;
      stats.max_luminance         <= running_max;
      stats.log_average_luminance <= (avg == 16'd0) ? 16'd1 : avg;
      stats.key_alpha             <= alpha;
      stats.frame_pixels          <= 23'(pixel_count);
      stats.flat_frame            <= flat;
    end
  end

  assign stats.valid = out_valid;

  always_comb begin
    state_next       = state;
    lum_cur_next     = lum_cur;
    last_cur_next    = last_cur;
    running_min_next = running_min;
    running_max_next = running_max;
    log_sum_next     = log_sum;
    pixel_count_next = pixel_count;
    avg_next         = avg;
    alpha_next       = alpha;
    bitpos_next      = bitpos;
    lmin_next        = lmin;
    lmax_next        = lmax;
    lgk_next         = lgk;
    mean_c_next      = mean_c;
    prod_a_next      = prod_a;
    prod_d_next      = prod_d;
    rhs_next         = rhs;
    out_valid_next   = out_valid && !stats.ready;
    out_load         = 1'b0;
    q_pop            = 1'b0;
    div_start        = 1'b0;

    case (state)
      slks_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop         = 1'b1;
          lum_cur_next  = q_item.lum;
          last_cur_next = q_item.last;
          state_next    = slks_pkg::ST_PIX;
        end
      end
      slks_pkg::ST_PIX: begin
        if (lg_done) begin
          if (!pixel_count[PIXEL_COUNT_BITS]) begin
            if (lum_cur < running_min) begin
              running_min_next = lum_cur;
            end
            if (lum_cur > running_max) begin
              running_max_next = lum_cur;
            end
            log_sum_next     = log_sum + LSUM_W'(lg_result);
            pixel_count_next = pixel_count + CNT_W'(1);
          end
          if (last_cur) begin
            avg_next    = 16'd0;
            bitpos_next = 4'd15;
            state_next  = slks_pkg::ST_AVG_SET;
          end else begin
            state_next = slks_pkg::ST_IDLE;
          end
        end
      end
      slks_pkg::ST_AVG_SET: begin
        if (cand > slks_pkg::LUM_MAX) begin
          if (bitpos == 4'd0) begin
            state_next = slks_pkg::ST_MIN;
          end else begin
            bitpos_next = bitpos - 4'd1;
          end
        end else begin
          state_next = slks_pkg::ST_AVG_MUL;
        end
      end
      slks_pkg::ST_AVG_MUL: begin
        if (lg_done) begin
          prod_a_next = PA_W'(lg_result) * PA_W'(cnt_eff);
          state_next  = slks_pkg::ST_AVG_CMP;
        end
      end
      slks_pkg::ST_AVG_CMP: begin
        if (prod_a <= PA_W'(log_sum)) begin
          avg_next = cand;
        end
        if (bitpos == 4'd0) begin
          state_next = slks_pkg::ST_MIN;
        end else begin
          bitpos_next = bitpos - 4'd1;
          state_next  = slks_pkg::ST_AVG_SET;
        end
      end
      slks_pkg::ST_MIN: begin
        if (lg_done) begin
          lmin_next  = lg_result;
          state_next = slks_pkg::ST_MAX;
        end
      end
      slks_pkg::ST_MAX: begin
        if (lg_done) begin
          lmax_next  = lg_result;
          state_next = slks_pkg::ST_KEY;
        end
      end
      slks_pkg::ST_KEY: begin
        if (lg_done) begin
          lgk_next = lg_result;
          if (flat || lmax <= lmin) begin
            alpha_next = key_base;
            state_next = slks_pkg::ST_OUT;
          end else if (key_base == 16'd0) begin
            alpha_next = 16'd0;
            state_next = slks_pkg::ST_OUT;
          end else begin
            div_start  = 1'b1;
            state_next = slks_pkg::ST_DIV;
          end
        end
      end
      slks_pkg::ST_DIV: begin
        if (div_done) begin
          if (quotient < LSUM_W'(lmin)) begin
            mean_c_next = lmin;
          end else if (quotient > LSUM_W'(lmax)) begin
            mean_c_next = lmax;
          end else begin
            mean_c_next = quotient[LGW-1:0];
          end
          state_next = slks_pkg::ST_RHS_MUL;
        end
      end
      slks_pkg::ST_RHS_MUL: begin
        prod_d_next = PD_W'(lgk) * PD_W'(den);
        state_next  = slks_pkg::ST_RHS_ADD;
      end
      slks_pkg::ST_RHS_ADD: begin
        rhs_next    = rhs_sum;
        alpha_next  = 16'd0;
        bitpos_next = 4'd15;
        state_next  = slks_pkg::ST_ALP_MUL;
      end
      slks_pkg::ST_ALP_MUL: begin
        if (lg_done) begin
          prod_d_next = PD_W'(lg_result) * PD_W'(den);
          state_next  = slks_pkg::ST_ALP_CMP;
        end
      end
      slks_pkg::ST_ALP_CMP: begin
        if ($signed({2'b00, prod_d}) <= rhs) begin
          alpha_next = alpha | bit_sel;
        end
        if (bitpos == 4'd0) begin
          state_next = slks_pkg::ST_OUT;
        end else begin
          bitpos_next = bitpos - 4'd1;
          state_next  = slks_pkg::ST_ALP_MUL;
        end
      end
      slks_pkg::ST_OUT: begin
        if (!out_valid || stats.ready) begin
          out_load         = 1'b1;
          out_valid_next   = 1'b1;
          running_min_next = 16'hFFFF;
          running_max_next = 16'd0;
          log_sum_next     = '0;
          pixel_count_next = '0;
          state_next       = slks_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = slks_pkg::ST_IDLE;
      end
    endcase
  end

  // log unit is started on entry to each state that waits on it
  always_comb begin
    lg_start = (state_next != state) &&
               (state_next inside {slks_pkg::ST_PIX, slks_pkg::ST_AVG_MUL,
                                   slks_pkg::ST_MIN, slks_pkg::ST_MAX,
                                   slks_pkg::ST_KEY, slks_pkg::ST_ALP_MUL});
    case (state_next)
      slks_pkg::ST_PIX:     lg_value = q_item.lum;
      slks_pkg::ST_AVG_MUL: lg_value = avg_next | (16'd1 << bitpos_next);
      slks_pkg::ST_ALP_MUL: lg_value = alpha_next | (16'd1 << bitpos_next);
      slks_pkg::ST_MIN:     lg_value = running_min;
      slks_pkg::ST_MAX:     lg_value = running_max;
      slks_pkg::ST_KEY:     lg_value = key_base;
      default:              lg_value = 16'd0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/scene_luminance_key_statistics.sv
// ----------------------------------------------------------------------------
// scene_luminance_key_statistics
// Frame luminance statistics with log-average luminance and automatic key.
//
// pixel: valid/ready request channel, one rgb pixel per request with a
//   last_pixel mark closing the frame. A four-entry queue holds luminance
//   codes ahead of the statistics sequencer.
// stats: valid/ready request channel, one result per frame, sent after the
//   last pixel. The result waits in an output register while the sequencer
//   goes on with the queued pixels of the next frame.
// cfg_write/cfg_data: write of key_base (Q0.16), taken on any enabled edge.
// Each pixel occupies the sequencer while the iterative log2 unit works on
//   it, one squaring per fraction bit; the next pixel waits in the queue.
// The end-of-frame work adds up to 35 log2 passes plus a divider pass.
// rst clears the statistics, the queue and the output valid flag and sets
//   key_base to 0.18. A stalled stats receiver holds the result; the
//   sequencer then waits at the next frame end and the queue fills up.
// ----------------------------------------------------------------------------
`default_nettype none

module scene_luminance_key_statistics #(
  parameter int PIXEL_COUNT_BITS = slks_pkg::PIXEL_COUNT_BITS,
  parameter int LOG_FRAC_BITS    = slks_pkg::LOG_FRAC_BITS,
  parameter int QUEUE_DEPTH      = slks_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  slks_pixel_if.sink       pixel,
  slks_stats_if.source     stats,
  input  wire logic        cfg_write,
  input  wire logic [15:0] cfg_data
);

  logic [15:0]    key_base;
  slks_pkg::pix_t q_item;
  logic           q_valid;
  logic           q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_base <= slks_pkg::KEY_BASE_RESET;
    end else if (cfg_write) begin
      key_base <= cfg_data;
    end
  end

  slks_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pixel),
    .q_item (q_item),
    .q_valid(q_valid),
    .q_pop  (q_pop)
  );

  slks_back #(
    .PIXEL_COUNT_BITS(PIXEL_COUNT_BITS),
    .LOG_FRAC_BITS   (LOG_FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .key_base(key_base),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .stats   (stats)
  );

`include "scene_luminance_key_statistics_assert.svh"

  `SLKS_ASSERT_IMP(a_min_le_max, clk, rst, stats.valid, stats.min_luminance <= stats.max_luminance)
  `SLKS_ASSERT_IMP(a_flat_match, clk, rst, stats.valid, stats.flat_frame == (stats.min_luminance == stats.max_luminance))
  `SLKS_ASSERT_IMP(a_pop_nonempty, clk, rst, q_pop, q_valid)
  `SLKS_ASSERT_NEXT(a_push_seen, clk, rst, pixel.valid && pixel.ready && !q_valid, q_valid)

endmodule

`default_nettype wire

FILE: bench/scene_luminance_key_statistics_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scene_luminance_key_statistics_checker
// Watches the pixel, stats and key_base write ports, keeps its own frame
// statistics and log2 arithmetic, predicts each frame result and compares
// every stats request field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module scene_luminance_key_statistics_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  slks_pixel_if            pixel,
  slks_stats_if            stats,
  input  wire logic        cfg_write,
  input  wire logic [15:0] cfg_data,
  output int               frames_pending,
  output int               errors
);

  typedef struct packed {
    logic [15:0] min_lum;
    logic [15:0] max_lum;
    logic [15:0] avg_lum;
    logic [15:0] alpha;
    logic [22:0] count;
    logic        flat;
  } frame_stats_t;

  frame_stats_t   frame_q[$];
  logic [15:0]    key_base;
  logic [15:0]    lum_min;
  logic [15:0]    lum_max;
  longint unsigned lg_total;
  longint unsigned pix_count;

  function automatic longint unsigned log2_fix(input logic [15:0] v);
    int unsigned k;
    longint unsigned x;
    longint unsigned frac;
    k = 0;
    frac = 0;
    if (v == 0) v = 1;
    while (k < 15 && (v >> (k + 1)) != 0) k++;
    x = longint'(v) << (30 - k);
    for (int i = 0; i < slks_pkg::LOG_FRAC_BITS; i++) begin
      x = (x * x) >> 30;
      frac = frac << 1;
      if (x >= (64'd1 << 31)) begin
        x = x >> 1;
        frac = frac | 1;
      end
    end
    return (longint'(k) << slks_pkg::LOG_FRAC_BITS) | frac;
  endfunction

  function automatic frame_stats_t close_frame();
    frame_stats_t fs;
    longint unsigned cnt, lmin, lmax, mean;
    longint signed den, num, rhs;
    logic [16:0] cand;
    logic [15:0] avg, alpha;
    cnt = (pix_count != 0) ? pix_count : 1;
    avg = 0;
    for (int b = 15; b >= 0; b--) begin
      cand = avg | (16'd1 << b);
      if (cand <= slks_pkg::LUM_MAX && log2_fix(cand[15:0]) * cnt <= lg_total)
        avg = cand[15:0];
    end
    if (avg == 0) avg = 1;
    lmin = log2_fix(lum_min);
    lmax = log2_fix(lum_max);
    if (lum_max == lum_min || lmax <= lmin) begin
      alpha = key_base;
    end else if (key_base == 0) begin
      alpha = 0;
    end else begin
      den = longint'(lmax - lmin);
      mean = lg_total / cnt;
      if (mean < lmin) mean = lmin;
      if (mean > lmax) mean = lmax;
      num = 2 * longint'(mean) - longint'(lmin) - longint'(lmax);
      rhs = longint'(log2_fix(key_base)) * den
          + num * (64'sd1 <<< (slks_pkg::LOG_FRAC_BITS + 1));
      alpha = 0;
      for (int b = 15; b >= 0; b--) begin
        cand = alpha | (16'd1 << b);
        if (longint'(log2_fix(cand[15:0])) * den <= rhs) alpha = cand[15:0];
      end
    end
    fs.min_lum = lum_min;
    fs.max_lum = lum_max;
    fs.avg_lum = avg;
    fs.alpha   = alpha;
    fs.count   = pix_count[22:0];
    fs.flat    = (lum_max == lum_min);
    return fs;
  endfunction

  always @(posedge clk) begin
    logic [15:0] lum;
    frame_stats_t want;
    if (rst) begin
      key_base  = slks_pkg::KEY_BASE_RESET;
      lum_min   = 16'hFFFF;
      lum_max   = 0;
      lg_total  = 0;
      pix_count = 0;
      frame_q.delete();
      errors    = 0;
    end else begin
      if (cfg_write) key_base = cfg_data;
      if (stats.valid && stats.ready) begin
        if (frame_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected stats request at %0t", $time);
        end else begin
          want = frame_q.pop_front();
          if (want != {stats.min_luminance, stats.max_luminance,
                       stats.log_average_luminance, stats.key_alpha,
                       stats.frame_pixels, stats.flat_frame}) begin
            errors++;
            if (errors <= 10)
              $display({"stats mismatch at %0t: exp min %0d max %0d avg %0d key %0d",
                        " n %0d flat %0d, got min %0d max %0d avg %0d key %0d",
                        " n %0d flat %0d"},
                       $time, want.min_lum, want.max_lum, want.avg_lum, want.alpha,
                       want.count, want.flat, stats.min_luminance, stats.max_luminance,
                       stats.log_average_luminance, stats.key_alpha, stats.frame_pixels,
                       stats.flat_frame);
          end
        end
      end
      if (pixel.valid && pixel.ready) begin
        lum = 16'(pixel.red_channel * slks_pkg::LUM_WEIGHT_R
                  + pixel.green_channel * slks_pkg::LUM_WEIGHT_G
                  + pixel.blue_channel * slks_pkg::LUM_WEIGHT_B);
        if (lum == 0) lum = 1;
        if (pix_count < (64'd1 << slks_pkg::PIXEL_COUNT_BITS)) begin
          if (lum < lum_min) lum_min = lum;
          if (lum > lum_max) lum_max = lum;
          lg_total += log2_fix(lum);
          pix_count++;
        end
        if (pixel.last_pixel) begin
          frame_q.push_back(close_frame());
          lum_min   = 16'hFFFF;
          lum_max   = 0;
          lg_total  = 0;
          pix_count = 0;
        end
      end
    end
    frames_pending = frame_q.size();
  end
endmodule

`default_nettype wire

FILE: bench/scene_luminance_key_statistics_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scene_luminance_key_statistics_tb
// Drives frames of rgb pixels through the luminance key statistics block
// under several key_base settings and idling patterns, and reports the
// verdict of the checker.
// ----------------------------------------------------------------------------
`default_nettype none

module scene_luminance_key_statistics_tb;
  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [15:0] cfg_data;
  int          frames_pending;
  int          errors;
  int          tx_idle;
  int          rx_idle;
  logic        rx_hold;
  int          sent;

  slks_pixel_if pix_ch ();
  slks_stats_if stat_ch ();

  scene_luminance_key_statistics dut (
    .clk       (clk),
    .rst       (rst),
    .pixel     (pix_ch),
    .stats     (stat_ch),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  scene_luminance_key_statistics_checker chk (
    .clk            (clk),
    .rst            (rst),
    .pixel          (pix_ch),
    .stats          (stat_ch),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .frames_pending (frames_pending),
    .errors         (errors)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  initial begin
    rx_hold = 1'b0;
    stat_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      stat_ch.ready <= 1'b0;
    end else begin
      stat_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_idle);
    end
  end

  task automatic hold_receiver(input int cycles);
    rx_hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    rx_hold <= 1'b0;
  endtask

  task automatic send_pixel(input logic [7:0] r, g, b, input logic last);
    while ($urandom_range(99) < tx_idle) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pix_ch.valid         <= 1'b1;
    pix_ch.red_channel   <= r;
    pix_ch.green_channel <= g;
    pix_ch.blue_channel  <= b;
    pix_ch.last_pixel    <= last;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    pix_ch.valid <= 1'b0;
    @(posedge clk);
    while (frames_pending != 0) @(posedge clk);
    repeat (800) @(posedge clk);
  endtask

  task automatic write_key(input logic [15:0] v);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [7:0] chan();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic random_frame();
    int n;
    logic [7:0] r, g, b;
    logic flat;
    n = ($urandom_range(19) == 0) ? $urandom_range(60, 30) : $urandom_range(16, 1);
    flat = ($urandom_range(9) == 0);
    r = chan();
    g = chan();
    b = chan();
    for (int i = 0; i < n; i++) begin
      if (!flat) begin
        r = chan();
        g = chan();
        b = chan();
      end
      send_pixel(r, g, b, i == n - 1);
    end
  endtask

  initial begin
    logic [15:0] keys[4];
    bit held;
    bit paused;
    keys[0] = 16'd11796;
    keys[1] = 16'd0;
    keys[2] = 16'hFFFF;
    keys[3] = 16'($urandom_range(65535));
    held = 0;
    paused = 0;
    sent = 0;
    tx_idle = 18;
    rx_idle = 79;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = 16'd0;
    pix_ch.valid = 1'b0;
    pix_ch.red_channel = 8'd0;
    pix_ch.green_channel = 8'd0;
    pix_ch.blue_channel = 8'd0;
    pix_ch.last_pixel = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_key(keys[0]);

    // black, white, single colours, black and white together, flat frame
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b1);
    send_pixel(8'd0, 8'd0, 8'd255, 1'b1);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    for (int i = 0; i < 5; i++) send_pixel(8'd100, 8'd50, 8'd25, i == 4);
    send_pixel(8'd254, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd1, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd1, 1'b0);
    send_pixel(8'd0, 8'd1, 8'd0, 1'b1);

    for (int p = 0; p < 4; p++) begin
      if (p != 0) begin
        drain();
        write_key(keys[p]);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
      end
      while (sent < (p + 1) * 225) begin
        if (sent < 300) begin
          tx_idle = 18;
          rx_idle = 79;
        end else if (sent < 600) begin
          tx_idle = 79;
          rx_idle = 18;
        end else begin
          tx_idle = 0;
          rx_idle = 0;
        end
        if (!held && sent >= 650) begin
          held = 1;
          fork
            hold_receiver(3000);
          join_none
        end
        if (!paused && sent >= 450) begin
          paused = 1;
          drain();
        end
        random_frame();
      end
    end
    drain();
    if (errors == 0) begin
      $display("scene_luminance_key_statistics_tb: done, clean");
    end else begin
      $display("scene_luminance_key_statistics_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("scene_luminance_key_statistics_tb: done, errors");
    $finish;
  end
endmodule

`default_nettype wire
